// ----- sv/fcull_pkg.sv -----
// fcull_pkg: types and constants shared by the frustum cull test block
// depends on nothing; used by fcull_regs, fcull_lane, frustum_cull_test and its testbench
package fcull_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NORM_FRAC  = 14;   // fraction bits of a Q1.14 normal
  localparam int ADDR_W     = 6;    // byte address of six 64-bit registers
  localparam int IDX_LSB    = 3;    // registers sit at 8*i
  localparam int IDX_W      = ADDR_W - IDX_LSB;
  localparam int DATA_W     = 64;

  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_SPHERE = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;

  // one plane register, d in the top field
  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
  } plane_t;

  // control from the top level to each plane lane
  typedef struct packed {
    logic en;    // whole pipe advances
    logic box;   // stage 1 item is a box query
  } ctl_t;

endpackage

// ----- sv/fcull_regs.sv -----
// fcull_regs: apb register file holding the six frustum planes
// depends on fcull_pkg
module fcull_regs (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [fcull_pkg::ADDR_W-1:0]             paddr,
  input  logic [fcull_pkg::DATA_W-1:0]             pwdata,
  output logic [fcull_pkg::DATA_W-1:0]             prdata,
  output fcull_pkg::plane_t [fcull_pkg::NUM_PLANES-1:0] planes
);

  fcull_pkg::plane_t [fcull_pkg::NUM_PLANES-1:0] plane_r;
  logic [fcull_pkg::IDX_W-1:0] idx;
  logic                        wr;

  assign idx = paddr[fcull_pkg::ADDR_W-1:fcull_pkg::IDX_LSB];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (wr) begin
      for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) begin
        if (idx == fcull_pkg::IDX_W'(i)) begin
          plane_r[i] <= pwdata;
        end
      end
    end
  end

  // unmapped addresses read as zero
  always_comb begin
    prdata = '0;
    for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) begin
      if (idx == fcull_pkg::IDX_W'(i)) begin
        prdata = plane_r[i];
      end
    end
  end

  assign planes = plane_r;

endmodule

// ----- sv/fcull_lane.sv -----
// fcull_lane: one plane's distance test, select and multiply then sum and compare
// depends on fcull_pkg
module fcull_lane #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  fcull_pkg::ctl_t               ctl,
  input  fcull_pkg::plane_t             plane,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic [COORD_WIDTH-2:0]        bias,   // stage 2 aligned radius, 0 unless sphere
  output logic                          excl    // stage 3 plane excludes the query
);

  localparam int PW = COORD_WIDTH + 16;   // product width
  // sum width, no overflow; the offset term alone needs 30 bits plus headroom
  localparam int SW = (COORD_WIDTH + 18 > 32) ? COORD_WIDTH + 18 : 32;

  logic signed [COORD_WIDTH-1:0] sx, sy, sz;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [PW-1:0] px_nxt, py_nxt, pz_nxt;
  logic signed [SW-1:0] sum;
  logic                 excl_r;

  // box: n.(min+max) + |n|.(max-min) = 2 n.(n<0 ? min : max)
  assign sx = (ctl.box && !plane.nx[15]) ? bx : ax;
  assign sy = (ctl.box && !plane.ny[15]) ? by : ay;
  assign sz = (ctl.box && !plane.nz[15]) ? bz : az;

  assign px_nxt = PW'(plane.nx * sx);
  assign py_nxt = PW'(plane.ny * sy);
  assign pz_nxt = PW'(plane.nz * sz);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
  end

  assign sum = {{(SW-PW){px_r[PW-1]}}, px_r}
             + {{(SW-PW){py_r[PW-1]}}, py_r}
             + {{(SW-PW){pz_r[PW-1]}}, pz_r}
             + {{(SW-30){plane.d[15]}}, plane.d, {fcull_pkg::NORM_FRAC{1'b0}}}
             + {{(SW-COORD_WIDTH-13){1'b0}}, bias, {fcull_pkg::NORM_FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      excl_r <= sum[SW-1];   // ties are inside
    end
  end

  assign excl = excl_r;

endmodule

// ----- sv/frustum_cull_test.sv -----
// frustum_cull_test: top level of the frustum cull test pipeline
// depends on fcull_pkg, fcull_regs and fcull_lane
//
// usage
//   software writes six planes (left, right, bottom, top, near, far) through
//   the apb port at byte address 8*i; each packs nx, ny, nz in q1.14 and the
//   offset d in q12.4, nx in the low 16 bits
//   each input transaction is one query: point, sphere or box (opcode 3 also
//   runs the box test); the result transaction carries out_inside_res, set
//   when no plane excludes the query, ties counting as inside
//   four register stages: input register, products, plane sums, output
//   register; each query moves through them in that order
//   throughput is one query per cycle while the result channel does not
//   stall, limited by the 18 parallel 16 x coord multipliers in stage two
//   all stages advance together; while a valid result is stalled the whole
//   pipe holds and in_stall is raised, so nothing is lost or repeated
//   reset clears every valid bit and all planes to zero, so every query
//   reports inside until planes are written
module frustum_cull_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // query channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_opcode,
  input  logic signed [COORD_WIDTH-1:0]      in_first_x,
  input  logic signed [COORD_WIDTH-1:0]      in_first_y,
  input  logic signed [COORD_WIDTH-1:0]      in_first_z,
  input  logic signed [COORD_WIDTH-1:0]      in_second_x,
  input  logic signed [COORD_WIDTH-1:0]      in_second_y,
  input  logic signed [COORD_WIDTH-1:0]      in_second_z,
  input  logic [COORD_WIDTH-2:0]             in_sphere_radius,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_inside_res,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fcull_pkg::ADDR_W-1:0]       paddr,
  input  logic [fcull_pkg::DATA_W-1:0]       pwdata,
  output logic [fcull_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  fcull_pkg::plane_t [fcull_pkg::NUM_PLANES-1:0] planes;
  fcull_pkg::ctl_t ctl;
  logic en;

  // stage valid bits
  logic v_s1_r, v_s2_r, v_s3_r, v_s4_r;

  // stage 1 query register
  logic [1:0]                    op_s1_r;
  logic signed [COORD_WIDTH-1:0] ax_s1_r, ay_s1_r, az_s1_r;
  logic signed [COORD_WIDTH-1:0] bx_s1_r, by_s1_r, bz_s1_r;
  logic [COORD_WIDTH-2:0]        r_s1_r;

  // stage 2 radius bias, zero unless sphere
  logic [COORD_WIDTH-2:0]        bias_s2_r, bias_s2_nxt;

  logic [fcull_pkg::NUM_PLANES-1:0] excl_s3;
  logic                             inside_r, inside_nxt;

  assign pready = 1'b1;

  fcull_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .planes  (planes)
  );

  // the pipe only holds when a finished result is waiting
  assign en       = ~(v_s4_r & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
      v_s2_r <= 1'b0;
      v_s3_r <= 1'b0;
      v_s4_r <= 1'b0;
    end else if (en) begin
      v_s1_r <= in_valid;
      v_s2_r <= v_s1_r;
      v_s3_r <= v_s2_r;
      v_s4_r <= v_s3_r;
    end
  end

  // query payload, no reset needed
  always_ff @(posedge clk) begin
    if (en) begin
      op_s1_r <= in_opcode;
      ax_s1_r <= in_first_x;
      ay_s1_r <= in_first_y;
      az_s1_r <= in_first_z;
      bx_s1_r <= in_second_x;
      by_s1_r <= in_second_y;
      bz_s1_r <= in_second_z;
      r_s1_r  <= in_sphere_radius;
    end
  end

  // sphere test: dist < -r  <=>  dist + r < 0
  assign bias_s2_nxt = (op_s1_r == fcull_pkg::OP_SPHERE) ? r_s1_r : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      bias_s2_r <= bias_s2_nxt;
    end
  end

  assign ctl.en  = en;
  assign ctl.box = op_s1_r[1];   // opcode 3 decodes as box too

  // one lane per plane, all working on the same query
  for (genvar i = 0; i < fcull_pkg::NUM_PLANES; i++) begin : g_lane
    fcull_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .plane (planes[i]),
      .ax    (ax_s1_r),
      .ay    (ay_s1_r),
      .az    (az_s1_r),
      .bx    (bx_s1_r),
      .by    (by_s1_r),
      .bz    (bz_s1_r),
      .bias  (bias_s2_r),
      .excl  (excl_s3[i])
    );
  end

  // inside only when no plane excludes
  assign inside_nxt = ~|excl_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      inside_r <= inside_nxt;
    end
  end

  assign out_valid      = v_s4_r;
  assign out_inside_res = inside_r;

  // valid bits move one stage per enabled cycle
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (v_s1_r && en) |=> v_s2_r)
    else $error("stage 1 item did not reach stage 2");

  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v_s3_r && en) |=> out_valid)
    else $error("stage 3 item did not reach the output register");

  // a held pipe keeps all of its valid bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable({v_s1_r, v_s2_r, v_s3_r, v_s4_r}))
    else $error("valid bits changed while the pipe was held");

  // a stalled result keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_inside_res))
    else $error("stalled result changed");

endmodule

// ----- tb/frustum_cull_test_tb.sv -----
// frustum_cull_test_tb: self-checking testbench for the frustum cull test block
// depends on fcull_pkg and frustum_cull_test; a scoreboard class predicts inside_res
module frustum_cull_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = 16;     // coordinate width of the block
  localparam int CLK_PERIOD  = 10;
  localparam int QUIET_LIMIT = 3000;   // cycles with no transaction before giving up
  localparam int LONG_HOLD   = 400;    // receiver hold-off that fills the pipe
  localparam int PIPE_LAT    = 8;      // settle time after the last result
  localparam int PHASE_ITEMS = 190;
  localparam int MAX_REPORTS = 10;

  // opcode 3 is decoded by its upper bit and runs the box test
  localparam logic [1:0] OP_BOX_ALIAS = 2'd3;

  // register map, one plane per 8-byte slot, two spare slots above
  localparam int REG_LEFT   = 0;
  localparam int REG_RIGHT  = 1;
  localparam int REG_BOTTOM = 2;
  localparam int REG_TOP    = 3;
  localparam int REG_NEAR   = 4;
  localparam int REG_FAR    = 5;
  localparam int REG_SPARE0 = 6;
  localparam int REG_SPARE1 = 7;

  localparam logic signed [15:0] UNIT_NORMAL = 16'sd16384;   // 1.0 in q1.14
  localparam logic [63:0] PLANE_MAX = {4{16'h7FFF}};
  localparam logic [63:0] PLANE_MIN = {4{16'h8000}};

  typedef enum {PLANES_AXIS, PLANES_TILTED, PLANES_MIXED} plane_kind_t;

  // one query as the input channel carries it
  typedef struct {
    logic [1:0]           op;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic [CW-2:0]        r;
  } query_t;

  // keeps its own copy of the planes and the queue of pending inside flags
  class cull_scoreboard_t;
    fcull_pkg::plane_t planes[fcull_pkg::NUM_PLANES];
    bit     expected_inside[$];
    int     errors;

    function new();
      foreach (planes[i]) planes[i] = '0;
      errors = 0;
    endfunction

    function void note_plane_write(int idx, logic [63:0] value);
      if (idx < fcull_pkg::NUM_PLANES) planes[idx] = value;
    endfunction

    // exact q.18 evaluation of all six planes; ties count as inside
    function bit inside_of(query_t q);
      longint ax, ay, az, bx, by, bz, rad, nx, ny, nz, dq, sum, ext, dist_q, scale;
      bit     in_frustum;
      ax = q.ax; ay = q.ay; az = q.az;
      bx = q.bx; by = q.by; bz = q.bz;
      rad = q.r;
      scale = 64'sd1 <<< fcull_pkg::NORM_FRAC;
      in_frustum = 1'b1;
      for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) begin
        nx = planes[i].nx;
        ny = planes[i].ny;
        nz = planes[i].nz;
        dq = planes[i].d;
        dq = dq * scale;
        if (q.op[1]) begin
          sum = nx * (ax + bx) + ny * (ay + by) + nz * (az + bz) + 2 * dq;
          ext = (nx < 0 ? -nx : nx) * (bx - ax) + (ny < 0 ? -ny : ny) * (by - ay)
              + (nz < 0 ? -nz : nz) * (bz - az);
          if (sum + ext < 0) in_frustum = 1'b0;
        end else begin
          dist_q = nx * ax + ny * ay + nz * az + dq;
          if (q.op == fcull_pkg::OP_SPHERE) begin
            if (dist_q < -(rad * scale)) in_frustum = 1'b0;
          end else if (dist_q < 0) begin
            in_frustum = 1'b0;
          end
        end
      end
      return in_frustum;
    endfunction

    function void note_query(query_t q);
      expected_inside.push_back(inside_of(q));
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_inside.size() == 0) begin
        if (errors < MAX_REPORTS) $display("result transaction with none pending, inside_res %b", got);
        errors++;
        return;
      end
      want = expected_inside.pop_front();
      if (got !== want) begin
        if (errors < MAX_REPORTS) $display("inside_res: expected %0b, got %b", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_inside.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_opcode;
  logic signed [CW-1:0] in_first_x, in_first_y, in_first_z;
  logic signed [CW-1:0] in_second_x, in_second_y, in_second_z;
  logic [CW-2:0]        in_sphere_radius;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_inside_res;
  logic                 psel, penable, pwrite;
  logic [fcull_pkg::ADDR_W-1:0] paddr;
  logic [fcull_pkg::DATA_W-1:0] pwdata;
  logic [fcull_pkg::DATA_W-1:0] prdata;
  logic                 pready;

  cull_scoreboard_t sb = new();

  int          send_idle_pct = 0;   // chance in percent of an idle cycle before a query
  int          recv_idle_pct = 0;   // chance in percent of a stall cycle
  int unsigned hold_req = 0;        // bumped to ask the receiver for a long hold-off
  int unsigned hold_ack = 0;
  int unsigned quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  frustum_cull_test #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_first_x      (in_first_x),
    .in_first_y      (in_first_y),
    .in_first_z      (in_first_z),
    .in_second_x     (in_second_x),
    .in_second_y     (in_second_y),
    .in_second_z     (in_second_z),
    .in_sphere_radius(in_sphere_radius),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_inside_res  (out_inside_res),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // monitors: all sample the values that stood before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_query(query_t'{in_opcode, in_first_x, in_first_y, in_first_z,
                               in_second_x, in_second_y, in_second_z, in_sphere_radius});
      end
      if (out_valid && !out_stall) sb.check_result(out_inside_res);
      // register write lands at the access edge; spare slots are dropped by the model
      if (psel && penable && pwrite && pready) begin
        sb.note_plane_write(int'(paddr >> fcull_pkg::IDX_LSB), pwdata);
      end
    end
  end

  // watchdog: any transaction on any port counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("frustum_cull_test: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stall cycles, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // put one query on the channel and hold it until the block takes it
  task automatic send_query(query_t q);
    in_valid         <= 1'b1;
    in_opcode        <= q.op;
    in_first_x       <= q.ax;
    in_first_y       <= q.ay;
    in_first_z       <= q.az;
    in_second_x      <= q.bx;
    in_second_y      <= q.by;
    in_second_z      <= q.bz;
    in_sphere_radius <= q.r;
    do @(posedge clk); while (in_stall);
  endtask

  // apb write: setup cycle, access cycle, then an idle cycle
  task automatic write_plane(int idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fcull_pkg::ADDR_W'(idx << fcull_pkg::IDX_LSB);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering queries and wait for every pending result, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic fill_planes(logic [63:0] value);
    for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) write_plane(i, value);
  endtask

  function automatic query_t mk_query(logic [1:0] op, int ax, int ay, int az,
                                      int bx, int by, int bz, int r);
    query_t q;
    q.op = op;
    q.ax = CW'(ax); q.ay = CW'(ay); q.az = CW'(az);
    q.bx = CW'(bx); q.by = CW'(by); q.bz = CW'(bz);
    q.r  = (CW-1)'(r);
    return q;
  endfunction

  // axis-aligned box frustum: plane i faces inward along one axis, offset in q12.4
  function automatic fcull_pkg::plane_t axis_plane(int idx, int offset);
    fcull_pkg::plane_t p;
    p = '0;
    case (idx)
      REG_LEFT:   p.nx = UNIT_NORMAL;
      REG_RIGHT:  p.nx = -UNIT_NORMAL;
      REG_BOTTOM: p.ny = UNIT_NORMAL;
      REG_TOP:    p.ny = -UNIT_NORMAL;
      REG_NEAR:   p.nz = UNIT_NORMAL;
      default:    p.nz = -UNIT_NORMAL;
    endcase
    p.d = 16'(offset);
    return p;
  endfunction

  // normal components within +-1.0, non-negative offset, so results split both ways
  function automatic fcull_pkg::plane_t tilted_plane();
    fcull_pkg::plane_t p;
    p.nx = 16'(int'($urandom_range(0, 32768)) - 16384);
    p.ny = 16'(int'($urandom_range(0, 32768)) - 16384);
    p.nz = 16'(int'($urandom_range(0, 32768)) - 16384);
    p.d  = 16'($urandom_range(0, 32767));
    return p;
  endfunction

  task automatic configure(plane_kind_t kind);
    logic [63:0] value;
    for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) begin
      case (kind)
        PLANES_AXIS:   value = axis_plane(i, $urandom_range(0, 32767));
        PLANES_TILTED: value = tilted_plane();
        default: begin
          // extremes and raw bit patterns mixed with ordinary planes
          case ($urandom_range(0, 3))
            0:       value = PLANE_MAX;
            1:       value = PLANE_MIN;
            2:       value = {$urandom(), $urandom()};
            default: value = tilted_plane();
          endcase
        end
      endcase
      write_plane(i, value);
    end
  endtask

  // mostly small coordinates near the frustum, the rest over the full range
  function automatic logic signed [CW-1:0] rand_coord();
    if ($urandom_range(0, 99) < 60) return CW'(int'($urandom_range(0, 5000)) - 2500);
    return CW'($urandom());
  endfunction

  function automatic query_t random_query();
    query_t      q;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    q.op = (pick == 0) ? OP_BOX_ALIAS : (pick < 4) ? fcull_pkg::OP_POINT :
           (pick < 7) ? fcull_pkg::OP_SPHERE : fcull_pkg::OP_BOX;
    q.ax = rand_coord();
    q.ay = rand_coord();
    q.az = rand_coord();
    if ($urandom_range(0, 3) == 0) begin
      // independent corners, often inverted
      q.bx = rand_coord();
      q.by = rand_coord();
      q.bz = rand_coord();
    end else begin
      q.bx = q.ax + CW'($urandom_range(0, 800));
      q.by = q.ay + CW'($urandom_range(0, 800));
      q.bz = q.az + CW'($urandom_range(0, 800));
    end
    q.r = ($urandom_range(0, 3) == 0) ? (CW-1)'($urandom()) : (CW-1)'($urandom_range(0, 1200));
    return q;
  endfunction

  // random stream; optionally asks for the long receiver hold-off or a full drain mid-way
  task automatic run_random(int count, bit with_hold, bit with_pause);
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == count / 4) hold_req <= hold_req + 1;
      if (with_pause && k == count / 2) begin
        drain();
      end else begin
        // each cycle idles with the given chance, so the idle share matches it
        while ($urandom_range(0, 99) < send_idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
      send_query(random_query());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_opcode        = fcull_pkg::OP_POINT;
    in_first_x       = '0;
    in_first_y       = '0;
    in_first_z       = '0;
    in_second_x      = '0;
    in_second_y      = '0;
    in_second_z      = '0;
    in_sphere_radius = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // planes still zero after reset: every query must come back inside
    send_query(mk_query(fcull_pkg::OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
    send_query(mk_query(fcull_pkg::OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    drain();

    // box frustum of half-width 100.0; probe ties and one-lsb misses on the left plane
    for (int i = 0; i < fcull_pkg::NUM_PLANES; i++) write_plane(i, axis_plane(i, 1600));
    // spare slots beyond the far plane must not disturb anything
    write_plane(REG_SPARE0, '1);
    write_plane(REG_SPARE1, PLANE_MIN);
    send_query(mk_query(fcull_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_POINT, -1600, 0, 0, 0, 0, 0, 0));      // on the plane
    send_query(mk_query(fcull_pkg::OP_POINT, -1601, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_SPHERE, -1700, 0, 0, 0, 0, 0, 100));   // just touching
    send_query(mk_query(fcull_pkg::OP_SPHERE, -1700, 0, 0, 0, 0, 0, 99));
    send_query(mk_query(fcull_pkg::OP_BOX, -1700, -5, -5, -1600, 5, 5, 0));  // face on the plane
    send_query(mk_query(fcull_pkg::OP_BOX, -1700, -5, -5, -1601, 5, 5, 0));
    send_query(mk_query(fcull_pkg::OP_BOX, -1595, 5, 5, -1605, -5, -5, 0));  // min above max
    send_query(mk_query(OP_BOX_ALIAS, -1700, -5, -5, -1600, 5, 5, 0));
    send_query(mk_query(fcull_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767));
    send_query(mk_query(fcull_pkg::OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    drain();

    // extreme register patterns, normals far from unit length
    fill_planes(PLANE_MAX);
    send_query(mk_query(fcull_pkg::OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 32767));
    drain();
    fill_planes(PLANE_MIN);
    send_query(mk_query(fcull_pkg::OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
    send_query(mk_query(fcull_pkg::OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
    send_query(mk_query(OP_BOX_ALIAS, -32768, -32768, -32768, 32767, 32767, 32767, 0));

    // random phases: two with each traffic pattern, new planes each time
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph / 2)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (ph % 3)
        0:       configure(PLANES_AXIS);
        1:       configure(PLANES_TILTED);
        default: configure(PLANES_MIXED);
      endcase
      // back-pressure fill in the busy phase, a full drain mid-stream in the last
      run_random(PHASE_ITEMS, ph == 4, ph == 5);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("frustum_cull_test: match");
    end else begin
      $display("frustum_cull_test: mismatch");
    end
    $finish;
  end

endmodule
